// ===== hdl/msync_pkg.sv =====
// Shared constants, types and the metric weight function of the syncopation scorer.
`timescale 1ns / 1ps

package msync_pkg;

  localparam int METER_MAX = 64;
  localparam int METER_W   = 7;
  localparam int POS_W     = $clog2(METER_MAX);
  localparam int WEIGHT_W  = 3;
  localparam int SCORE_W   = 12;
  localparam int CODE_W    = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [METER_W-1:0]  METER_RESET     = METER_W'(4);
  localparam logic [SCORE_W-1:0]  SCORE_MAX       = {SCORE_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] DOWNBEAT_WEIGHT = WEIGHT_W'(4);
  localparam logic [WEIGHT_W-1:0] HALF_WEIGHT     = WEIGHT_W'(3);
  localparam logic [WEIGHT_W-1:0] EVEN_WEIGHT     = WEIGHT_W'(2);
  localparam logic [WEIGHT_W-1:0] ODD_WEIGHT      = WEIGHT_W'(1);

  localparam logic [CODE_W-1:0] CODE_REST = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_HIT  = CODE_W'(1);

  localparam logic [PADDR_W-1:0] REG_METER_LENGTH = PADDR_W'(0);

  typedef logic [METER_W-1:0]  meter_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [SCORE_W-1:0]  score_t;

  function automatic weight_t metric_weight(pos_t pos, meter_t meter);
    meter_t half;
    half = meter >> 1;
    if (pos == '0) begin
      return DOWNBEAT_WEIGHT;
    end else if ({1'b0, pos} == half) begin
      return HALF_WEIGHT;
    end else if (!pos[0]) begin
      return EVEN_WEIGHT;
    end else begin
      return ODD_WEIGHT;
    end
  endfunction

endpackage

// ===== hdl/metric_syncopation_scorer.sv =====
// Top level of the metric syncopation scorer: input register, scoring logic and result register.
`timescale 1ns / 1ps

// The block takes one pattern step per cycle and keeps a sustained rate of one step per
// cycle unless a last step waits on a full, stalled result register; a step is held in
// the input register, and its score, produced only on a step marked last, is written to
// the result register as that step leaves. Weight lookup, pair compare and the saturating
// add all sit between those two registers. meter_length is written over the APB port at
// byte address 0 and should only be changed while the block is idle.
module metric_syncopation_scorer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [msync_pkg::CODE_W-1:0] in_step_code,
  input  logic                         in_last_step,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [msync_pkg::SCORE_W-1:0] out_score,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msync_pkg::PADDR_W-1:0] paddr,
  input  logic [msync_pkg::PDATA_W-1:0] pwdata,
  output logic [msync_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import msync_pkg::*;

  meter_t              meter_r;
  logic                s1_valid_r;
  logic [CODE_W-1:0]   s1_code_r;
  logic                s1_last_r;
  logic                out_valid_r;
  score_t              out_score_r;

  pos_t                bar_position_r, bar_position_nxt;
  logic                prior_was_hit_r, prior_was_hit_nxt;
  weight_t             prior_weight_r, prior_weight_nxt;
  logic                opening_was_rest_r, opening_was_rest_nxt;
  logic                at_pattern_start_r, at_pattern_start_nxt;
  score_t              running_score_r, running_score_nxt;

  logic                advance;
  logic                in_accept;
  meter_t              meter_eff;
  weight_t             w;
  logic                is_hit, is_rest, opening_rest_eff;
  weight_t             pair_add, wrap_add;
  logic [SCORE_W+1:0]  total;
  score_t              total_sat;
  meter_t              pos_inc;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_METER_LENGTH) ?
                  {{(PDATA_W-METER_W){1'b0}}, meter_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meter_r <= METER_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_METER_LENGTH) begin
      meter_r <= pwdata[METER_W-1:0];
    end
  end

  // The stage moves on unless it holds a last step and the result register is full and stalled.
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (meter_r == '0) begin
      meter_eff = meter_t'(1);
    end else if (meter_r > meter_t'(METER_MAX)) begin
      meter_eff = meter_t'(METER_MAX);
    end else begin
      meter_eff = meter_r;
    end
  end

  always_comb begin
    w                = metric_weight(bar_position_r, meter_eff);
    is_hit           = (s1_code_r == CODE_HIT);
    is_rest          = (s1_code_r == CODE_REST);
    opening_rest_eff = at_pattern_start_r ? is_rest : opening_was_rest_r;

    pair_add = '0;
    if (!at_pattern_start_r && prior_was_hit_r && is_rest && w > prior_weight_r) begin
      pair_add = w - prior_weight_r;
    end
    wrap_add = '0;
    if (s1_last_r && is_hit && opening_rest_eff && DOWNBEAT_WEIGHT > w) begin
      wrap_add = DOWNBEAT_WEIGHT - w;
    end

    total     = {2'b00, running_score_r} + {{(SCORE_W-1){1'b0}}, pair_add}
              + {{(SCORE_W-1){1'b0}}, wrap_add};
    total_sat = (total > {2'b00, SCORE_MAX}) ? SCORE_MAX : total[SCORE_W-1:0];

    pos_inc = {1'b0, bar_position_r} + meter_t'(1);

    bar_position_nxt     = bar_position_r;
    prior_was_hit_nxt    = prior_was_hit_r;
    prior_weight_nxt     = prior_weight_r;
    opening_was_rest_nxt = opening_was_rest_r;
    at_pattern_start_nxt = at_pattern_start_r;
    running_score_nxt    = running_score_r;

    if (advance) begin
      if (s1_last_r) begin
        bar_position_nxt     = '0;
        prior_was_hit_nxt    = 1'b0;
        prior_weight_nxt     = '0;
        opening_was_rest_nxt = 1'b0;
        at_pattern_start_nxt = 1'b1;
        running_score_nxt    = '0;
      end else begin
        bar_position_nxt     = (pos_inc >= meter_eff) ? '0 : pos_inc[POS_W-1:0];
        prior_was_hit_nxt    = is_hit;
        prior_weight_nxt     = w;
        opening_was_rest_nxt = opening_rest_eff;
        at_pattern_start_nxt = 1'b0;
        running_score_nxt    = total_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      bar_position_r     <= '0;
      prior_was_hit_r    <= 1'b0;
      prior_weight_r     <= '0;
      opening_was_rest_r <= 1'b0;
      at_pattern_start_r <= 1'b1;
      running_score_r    <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      bar_position_r     <= bar_position_nxt;
      prior_was_hit_r    <= prior_was_hit_nxt;
      prior_weight_r     <= prior_weight_nxt;
      opening_was_rest_r <= opening_was_rest_nxt;
      at_pattern_start_r <= at_pattern_start_nxt;
      running_score_r    <= running_score_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_code_r <= in_step_code;
      s1_last_r <= in_last_step;
    end
    if (advance && s1_last_r) begin
      out_score_r <= total_sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_score = out_score_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the metric syncopation scorer with its own score predictor.
`timescale 1ns / 1ps

module testbench;
  import msync_pkg::*;

  localparam logic [CODE_W-1:0] CODE_NEITHER     = CODE_W'(2);
  localparam logic [CODE_W-1:0] CODE_NEITHER_ALT = CODE_W'(3);
  localparam int STUCK_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int RANDOM_STEPS    = 1900;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CODE_W-1:0]   in_step_code;
  logic                in_last_step;
  logic                out_valid;
  logic                out_stall;
  logic [SCORE_W-1:0]  out_score;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predicted block state.
  meter_t  meter_reg;
  pos_t    bar_pos;
  logic    prev_hit;
  weight_t prev_weight;
  logic    opening_rest;
  logic    pattern_start;
  score_t  score_acc;
  score_t  expected_scores[$];

  int      error_count;
  int      stuck_cycles;
  int      out_hold;
  int      out_draw;
  bit      in_idle_en;
  bit      out_idle_en;
  score_t  expected_score;

  metric_syncopation_scorer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_step_code (in_step_code),
    .in_last_step (in_last_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_score    (out_score),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic weight_t weight_for(pos_t pos, int meter);
    if (pos == '0) begin
      return DOWNBEAT_WEIGHT;
    end
    if (int'(pos) == meter / 2) begin
      return HALF_WEIGHT;
    end
    if (!pos[0]) begin
      return EVEN_WEIGHT;
    end
    return ODD_WEIGHT;
  endfunction

  function automatic void clear_pattern_state();
    bar_pos = '0;
    prev_hit = 1'b0;
    prev_weight = '0;
    opening_rest = 1'b0;
    pattern_start = 1'b1;
    score_acc = '0;
  endfunction

  function automatic void score_add(int amount);
    int sum;
    sum = int'(score_acc) + amount;
    score_acc = (sum > int'(SCORE_MAX)) ? SCORE_MAX : score_t'(sum);
  endfunction

  function automatic void predict_step(logic [CODE_W-1:0] code, logic last);
    int      meter;
    weight_t w;
    logic    is_hit;
    logic    is_rest;
    meter = int'(meter_reg);
    if (meter == 0) begin
      meter = 1;
    end
    if (meter > METER_MAX) begin
      meter = METER_MAX;
    end
    w = weight_for(bar_pos, meter);
    is_hit = (code == CODE_HIT);
    is_rest = (code == CODE_REST);
    if (pattern_start) begin
      opening_rest = is_rest;
    end else if (prev_hit && is_rest && w > prev_weight) begin
      score_add(int'(w) - int'(prev_weight));
    end
    if (last) begin
      if (is_hit && opening_rest && DOWNBEAT_WEIGHT > w) begin
        score_add(int'(DOWNBEAT_WEIGHT) - int'(w));
      end
      expected_scores.push_back(score_acc);
      clear_pattern_state();
    end else begin
      pattern_start = 1'b0;
      prev_hit = is_hit;
      prev_weight = w;
      if (int'(bar_pos) + 1 >= meter) begin
        bar_pos = '0;
      end else begin
        bar_pos = bar_pos + 1'b1;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_step(input logic [CODE_W-1:0] code, input logic last);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_step_code <= code;
    in_last_step <= last;
    do @(posedge clk); while (in_stall);
    predict_step(code, last);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_meter(input meter_t value);
    logic [PDATA_W-1:0] noise;
    wait_idle();
    noise = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_METER_LENGTH;
    pwdata <= {noise[PDATA_W-1:METER_W], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    meter_reg = value;
    @(posedge clk);
    if (prdata !== {{(PDATA_W-METER_W){1'b0}}, value}) begin
      report_mismatch($sformatf("meter read back %0d, written %0d", prdata, value));
    end
  endtask

  function automatic logic [CODE_W-1:0] random_code();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) begin
      return CODE_REST;
    end
    if (r < 17) begin
      return CODE_HIT;
    end
    if (r == 17) begin
      return CODE_NEITHER;
    end
    return CODE_NEITHER_ALT;
  endfunction

  function automatic meter_t random_meter();
    case ($urandom_range(0, 9))
      0: return meter_t'(0);
      1: return meter_t'(1);
      2: return meter_t'(2);
      3: return meter_t'(METER_MAX);
      4: return meter_t'($urandom_range(METER_MAX + 1, 127));
      5: return meter_t'($urandom_range(3, 8));
      default: return meter_t'($urandom_range(1, METER_MAX));
    endcase
  endfunction

  // The reset meter of four: a syncopated bar, then a bar of two hits and two steps that are neither.
  task automatic test_reset_meter();
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b1);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_NEITHER, 1'b0);
    send_step(CODE_NEITHER_ALT, 1'b1);
  endtask

  task automatic test_single_step();
    send_step(CODE_HIT, 1'b1);
    send_step(CODE_REST, 1'b1);
    send_step(CODE_NEITHER, 1'b1);
    send_step(CODE_NEITHER_ALT, 1'b1);
  endtask

  task automatic test_meter_extremes();
    write_meter(meter_t'(0));
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_REST, 1'b1);
    write_meter(meter_t'(1));
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_REST, 1'b1);
    write_meter(meter_t'(METER_MAX));
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b1);
    write_meter(meter_t'(127));
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_HIT, 1'b1);
  endtask

  // The position counter stands past the new, shorter meter and wraps to zero on the next step.
  task automatic test_meter_change();
    int i;
    write_meter(meter_t'(METER_MAX));
    for (i = 0; i < 10; i++) begin
      send_step(i[0] ? CODE_HIT : CODE_REST, 1'b0);
    end
    write_meter(meter_t'(4));
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b0);
    send_step(CODE_REST, 1'b0);
    send_step(CODE_HIT, 1'b1);
  endtask

  task automatic test_random(input int total);
    int sent;
    int n_phase;
    int pattern_len;
    int i;
    sent = 0;
    while (sent < total) begin
      write_meter(random_meter());
      in_idle_en = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: pattern_len = 1;
        1, 2, 3, 4: pattern_len = 4;
        5, 6, 7: pattern_len = 12;
        8: pattern_len = 40;
        default: pattern_len = 100;
      endcase
      n_phase = $urandom_range(20, 120);
      for (i = 0; i < n_phase; i++) begin
        send_step(random_code(), $urandom_range(0, pattern_len - 1) == 0);
      end
      sent += n_phase;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end else if (out_valid === 1'b1 && !out_stall) begin
      out_draw = out_idle_en ? $urandom_range(0, 12) : 0;
      out_hold <= out_draw;
      out_stall <= (out_draw > 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_scores.size() == 0) begin
        report_mismatch($sformatf("score %0d with no pattern pending", out_score));
      end else begin
        expected_score = expected_scores.pop_front();
        if (out_score !== expected_score) begin
          report_mismatch($sformatf("score %0d, predicted %0d", out_score, expected_score));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_step_code <= CODE_REST;
    in_last_step <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_METER_LENGTH;
    pwdata <= '0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    meter_reg = METER_RESET;
    clear_pattern_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_meter();
    test_single_step();
    test_meter_extremes();
    test_meter_change();
    test_random(RANDOM_STEPS);

    wait_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
